// ----- rtl/sws_pkg.sv -----
// Shared types and constants for the sliding-window sender.
// No dependencies; used by sws_cfg and sliding_window_sender.
`default_nettype none

package sws_pkg;

    // Field widths fixed by the port list
    localparam int MODE_W   = 2;
    localparam int SEQ_W    = 4;
    localparam int ID_W     = 16;
    localparam int LEN_W    = 16;
    localparam int STATUS_W = 3;
    localparam int LIMIT_W  = 4;

    // Sequence numbers run 1 to SEQ_MAX and wrap
    localparam logic [SEQ_W-1:0] SEQ_MAX = SEQ_W'(8);

    // In-flight FIFO
    localparam int FLIGHT_DEPTH = 8;
    localparam int FL_PTR_W     = $clog2(FLIGHT_DEPTH);
    localparam int FL_CNT_W     = $clog2(FLIGHT_DEPTH + 1);

    // Backlog FIFO
    localparam int BACKLOG_DEPTH = 16;
    localparam int BL_PTR_W      = (BACKLOG_DEPTH > 1) ? $clog2(BACKLOG_DEPTH) : 1;
    localparam int BL_CNT_W      = $clog2(BACKLOG_DEPTH + 1);

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_WINDOW_LIMIT = 1'b0;
    localparam logic [LIMIT_W-1:0] WINDOW_LIMIT_RESET = LIMIT_W'(8);

    // Event kinds
    localparam logic [MODE_W-1:0] MODE_NEW  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NACK = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_SENT    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ACKED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [ID_W-1:0]  id;
        logic [LEN_W-1:0] len;
    } pkt_t;

endpackage

`default_nettype wire

// ----- rtl/sliding_window_sender.sv -----
// Top level of the sliding-window sender: event decode, in-flight and backlog FIFOs.
// Depends on sws_pkg and sws_cfg.
//
// Takes one event (new packet, ACK or NACK) per clock: busy never rises, so an
// event may be issued with start in every cycle. Each event yields exactly one
// result, shown on the result ports for one cycle with result_valid high on the
// cycle after start; the receiver must take it then. The whole FIFO and counter
// update for an event is combinational between the input and the result
// register, which sets the rate of one event per clock. Write window_limit only
// while no event is in progress.
`default_nettype none

module sliding_window_sender (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [sws_pkg::MODE_W-1:0]        mode,
    input  wire logic [sws_pkg::LEN_W-1:0]         packet_length,
    output logic                                   result_valid,
    output logic                                   sent,
    output logic      [sws_pkg::SEQ_W-1:0]         sent_seq,
    output logic      [sws_pkg::ID_W-1:0]          sent_id,
    output logic      [sws_pkg::LEN_W-1:0]         sent_length,
    output logic      [sws_pkg::STATUS_W-1:0]      status,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [sws_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [sws_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [sws_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                   pready
);
    import sws_pkg::*;

    logic [FL_CNT_W-1:0] limit_eff;

    sws_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .limit_eff (limit_eff)
    );

    // Control state
    logic [SEQ_W-1:0]    last_seq_reg,   last_seq_next;
    logic [ID_W-1:0]     pkt_cnt_reg,    pkt_cnt_next;
    logic [FL_PTR_W-1:0] fl_head_reg,    fl_head_next;
    logic [FL_PTR_W-1:0] fl_tail_reg,    fl_tail_next;
    logic [FL_CNT_W-1:0] fl_count_reg,   fl_count_next;
    logic [BL_PTR_W-1:0] bl_head_reg,    bl_head_next;
    logic [BL_PTR_W-1:0] bl_tail_reg,    bl_tail_next;
    logic [BL_CNT_W-1:0] bl_count_reg,   bl_count_next;
    logic                valid_reg,      valid_next;

    // Result payload
    logic                sent_reg,       sent_next;
    pkt_t                res_pkt_reg,    res_pkt_next;
    logic [STATUS_W-1:0] status_reg,     status_next;

    // Packet stores
    pkt_t flight_store_reg  [FLIGHT_DEPTH];
    pkt_t backlog_store_reg [BACKLOG_DEPTH];

    logic    fl_we;
    pkt_t    fl_wdata;
    logic    bl_we;
    pkt_t    bl_wdata;
    pkt_t    fl_head_pkt;
    pkt_t    bl_head_pkt;
    pkt_t    new_pkt;
    logic [SEQ_W-1:0]    seq_inc;
    logic [FL_PTR_W-1:0] fl_head_inc;
    logic [FL_PTR_W-1:0] fl_tail_inc;
    logic [BL_PTR_W-1:0] bl_head_inc;
    logic [BL_PTR_W-1:0] bl_tail_inc;
    logic [FL_CNT_W-1:0] fl_count_dec;

    assign busy = 1'b0;

    assign fl_head_pkt = flight_store_reg[fl_head_reg];
    assign bl_head_pkt = backlog_store_reg[bl_head_reg];

    assign seq_inc = (last_seq_reg >= SEQ_MAX) ? SEQ_W'(1) : last_seq_reg + SEQ_W'(1);
    assign new_pkt = '{seq: seq_inc, id: pkt_cnt_reg + ID_W'(1), len: packet_length};

    assign fl_head_inc = (32'(fl_head_reg) == FLIGHT_DEPTH - 1) ? '0
                                                                : fl_head_reg + FL_PTR_W'(1);
    assign fl_tail_inc = (32'(fl_tail_reg) == FLIGHT_DEPTH - 1) ? '0
                                                                : fl_tail_reg + FL_PTR_W'(1);
    assign bl_head_inc = (32'(bl_head_reg) == BACKLOG_DEPTH - 1) ? '0
                                                                 : bl_head_reg + BL_PTR_W'(1);
    assign bl_tail_inc = (32'(bl_tail_reg) == BACKLOG_DEPTH - 1) ? '0
                                                                 : bl_tail_reg + BL_PTR_W'(1);
    assign fl_count_dec = fl_count_reg - FL_CNT_W'(1);

    always_comb
    begin
        last_seq_next = last_seq_reg;
        pkt_cnt_next  = pkt_cnt_reg;
        fl_head_next  = fl_head_reg;
        fl_tail_next  = fl_tail_reg;
        fl_count_next = fl_count_reg;
        bl_head_next  = bl_head_reg;
        bl_tail_next  = bl_tail_reg;
        bl_count_next = bl_count_reg;
        fl_we         = 1'b0;
        fl_wdata      = new_pkt;
        bl_we         = 1'b0;
        bl_wdata      = new_pkt;
        valid_next    = start;
        sent_next     = 1'b0;
        res_pkt_next  = '0;
        status_next   = ST_SENT;

        if (start)
        begin
            case (mode)
                MODE_NEW:
                begin
                    // Seq and id are consumed even when the packet is dropped
                    last_seq_next = seq_inc;
                    pkt_cnt_next  = new_pkt.id;
                    if (bl_count_reg == '0 && fl_count_reg < limit_eff)
                    begin
                        fl_we         = 1'b1;
                        fl_tail_next  = fl_tail_inc;
                        fl_count_next = fl_count_reg + FL_CNT_W'(1);
                        sent_next     = 1'b1;
                        res_pkt_next  = new_pkt;
                        status_next   = ST_SENT;
                    end
                    else if (32'(bl_count_reg) < BACKLOG_DEPTH)
                    begin
                        bl_we         = 1'b1;
                        bl_tail_next  = bl_tail_inc;
                        bl_count_next = bl_count_reg + BL_CNT_W'(1);
                        status_next   = ST_QUEUED;
                    end
                    else
                    begin
                        status_next = ST_DROPPED;
                    end
                end
                default:
                begin
                    if (fl_count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else if (mode == MODE_ACK)
                    begin
                        // Retire the oldest, then refill from the backlog if room
                        fl_head_next = fl_head_inc;
                        if (bl_count_reg != '0 && fl_count_dec < limit_eff)
                        begin
                            fl_we         = 1'b1;
                            fl_wdata      = bl_head_pkt;
                            fl_tail_next  = fl_tail_inc;
                            bl_head_next  = bl_head_inc;
                            bl_count_next = bl_count_reg - BL_CNT_W'(1);
                            sent_next     = 1'b1;
                            res_pkt_next  = bl_head_pkt;
                            status_next   = ST_SENT;
                        end
                        else
                        begin
                            fl_count_next = fl_count_dec;
                            status_next   = ST_ACKED;
                        end
                    end
                    else
                    begin
                        // NACK (and the unused code): resend oldest, rotate to tail
                        fl_we        = 1'b1;
                        fl_wdata     = fl_head_pkt;
                        fl_head_next = fl_head_inc;
                        fl_tail_next = fl_tail_inc;
                        sent_next    = 1'b1;
                        res_pkt_next = fl_head_pkt;
                        status_next  = ST_SENT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_seq_reg <= '0;
            pkt_cnt_reg  <= '0;
            fl_head_reg  <= '0;
            fl_tail_reg  <= '0;
            fl_count_reg <= '0;
            bl_head_reg  <= '0;
            bl_tail_reg  <= '0;
            bl_count_reg <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            last_seq_reg <= last_seq_next;
            pkt_cnt_reg  <= pkt_cnt_next;
            fl_head_reg  <= fl_head_next;
            fl_tail_reg  <= fl_tail_next;
            fl_count_reg <= fl_count_next;
            bl_head_reg  <= bl_head_next;
            bl_tail_reg  <= bl_tail_next;
            bl_count_reg <= bl_count_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sent_reg    <= sent_next;
        res_pkt_reg <= res_pkt_next;
        status_reg  <= status_next;
        if (fl_we)
        begin
            flight_store_reg[fl_tail_reg] <= fl_wdata;
        end
        if (bl_we)
        begin
            backlog_store_reg[bl_tail_reg] <= bl_wdata;
        end
    end

    assign result_valid = valid_reg;
    assign sent         = sent_reg;
    assign sent_seq     = res_pkt_reg.seq;
    assign sent_id      = res_pkt_reg.id;
    assign sent_length  = res_pkt_reg.len;
    assign status       = status_reg;

endmodule

`default_nettype wire

// ----- rtl/sws_cfg.sv -----
// APB-style configuration register for the sliding-window sender.
// Holds window_limit and presents it clamped to 1..FLIGHT_DEPTH. Uses sws_pkg.
`default_nettype none

module sws_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [sws_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [sws_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [sws_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                   pready,
    output logic      [sws_pkg::FL_CNT_W-1:0]      limit_eff
);
    import sws_pkg::*;

    logic [LIMIT_W-1:0] window_limit_reg;
    logic [LIMIT_W-1:0] window_limit_next;
    logic               wr_en;
    logic               sel_limit;

    assign pready    = 1'b1;
    assign sel_limit = (paddr[CFG_ADDR_W-1] == REG_WINDOW_LIMIT);
    assign wr_en     = psel && penable && pwrite && pready;

    always_comb
    begin
        window_limit_next = window_limit_reg;
        if (wr_en && sel_limit)
        begin
            window_limit_next = pwdata[LIMIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_limit_reg <= WINDOW_LIMIT_RESET;
        end
        else
        begin
            window_limit_reg <= window_limit_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (sel_limit)
        begin
            prdata = CFG_DATA_W'(window_limit_reg);
        end
    end

    // Zero acts as one, anything past the FIFO depth acts as full depth
    always_comb
    begin
        if (window_limit_reg == '0)
        begin
            limit_eff = FL_CNT_W'(1);
        end
        else if (32'(window_limit_reg) > FLIGHT_DEPTH)
        begin
            limit_eff = FL_CNT_W'(FLIGHT_DEPTH);
        end
        else
        begin
            limit_eff = FL_CNT_W'(window_limit_reg);
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking bench for sliding_window_sender: table-driven directed events, then
// randomized phases across window limits; table values or a local predictor score each result.
// Depends on sws_pkg and the sliding_window_sender RTL.
`timescale 1ns / 1ps

module testbench;
    import sws_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_EVENTS  = 125;
    localparam int PHASE_COUNT   = 10;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] ADDR_WINDOW_LIMIT = '0;

    typedef struct packed {
        logic                sent;
        logic [SEQ_W-1:0]    seq;
        logic [ID_W-1:0]     id;
        logic [LEN_W-1:0]    len;
        logic [STATUS_W-1:0] status;
    } tx_result_t;

    typedef enum {ROW_EVENT, ROW_CONFIG} row_kind_e;
    typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} event_mix_e;

    typedef struct {
        row_kind_e          kind;
        logic [MODE_W-1:0]  mode;
        logic [LEN_W-1:0]   len;
        int                 reps;
        bit                 typed;
        tx_result_t         want;
    } plan_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [MODE_W-1:0] mode;
    logic [LEN_W-1:0] packet_length;
    logic result_valid;
    logic sent;
    logic [SEQ_W-1:0] sent_seq;
    logic [ID_W-1:0] sent_id;
    logic [LEN_W-1:0] sent_length;
    logic [STATUS_W-1:0] status;
    logic psel;
    logic penable;
    logic pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    sliding_window_sender u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .packet_length (packet_length),
        .result_valid  (result_valid),
        .sent          (sent),
        .sent_seq      (sent_seq),
        .sent_id       (sent_id),
        .sent_length   (sent_length),
        .status        (status),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Predictor state
    logic [LIMIT_W-1:0] win_limit;
    logic [SEQ_W-1:0]   seq_last;
    logic [ID_W-1:0]    id_last;
    pkt_t               flight_q[$];
    pkt_t               backlog_q[$];

    tx_result_t expected_q[$];
    plan_row_t  plan[$];
    int errors;
    int cycles = 0;
    int events_issued;
    int results_seen;
    int status_seen[8];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Run stopped at cycle limit with %0d results outstanding",
                     expected_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic tx_result_t res(input logic s, input logic [SEQ_W-1:0] q,
                                       input logic [ID_W-1:0] i, input logic [LEN_W-1:0] l,
                                       input logic [STATUS_W-1:0] st);
        tx_result_t r;
        r.sent   = s;
        r.seq    = q;
        r.id     = i;
        r.len    = l;
        r.status = st;
        return r;
    endfunction

    // Apply one event to the predictor state and return the result it yields.
    function automatic tx_result_t advance_sender(input logic [MODE_W-1:0] m,
                                                  input logic [LEN_W-1:0] l);
        tx_result_t r;
        pkt_t p;
        int lim;
        r = '0;
        lim = (win_limit == 0) ? 1 : (win_limit > FLIGHT_DEPTH) ? FLIGHT_DEPTH : win_limit;
        if (m == MODE_NEW)
        begin
            seq_last = (seq_last >= SEQ_MAX) ? SEQ_W'(1) : seq_last + 1'b1;
            id_last  = id_last + 1'b1;
            p.seq = seq_last;
            p.id  = id_last;
            p.len = l;
            // Keep order: anything waiting means the new packet waits too
            if (backlog_q.size() == 0 && flight_q.size() < lim)
            begin
                flight_q.push_back(p);
                r = res(1'b1, p.seq, p.id, p.len, ST_SENT);
            end
            else if (backlog_q.size() < BACKLOG_DEPTH)
            begin
                backlog_q.push_back(p);
                r.status = ST_QUEUED;
            end
            else
                r.status = ST_DROPPED;
        end
        else if (flight_q.size() == 0)
            r.status = ST_EMPTY;
        else if (m == MODE_ACK)
        begin
            p = flight_q.pop_front();
            if (backlog_q.size() > 0 && flight_q.size() < lim)
            begin
                p = backlog_q.pop_front();
                flight_q.push_back(p);
                r = res(1'b1, p.seq, p.id, p.len, ST_SENT);
            end
            else
                r.status = ST_ACKED;
        end
        else
        begin
            // NACK and the spare code: resend oldest, rotate it to the tail
            p = flight_q.pop_front();
            flight_q.push_back(p);
            r = res(1'b1, p.seq, p.id, p.len, ST_SENT);
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        tx_result_t want;
        if (rst_n && result_valid)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $error("result beat with no event outstanding");
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                compare_field("sent", 32'(want.sent), 32'(sent));
                compare_field("sent_seq", 32'(want.seq), 32'(sent_seq));
                compare_field("sent_id", 32'(want.id), 32'(sent_id));
                compare_field("sent_length", 32'(want.len), 32'(sent_length));
                compare_field("status", 32'(want.status), 32'(status));
            end
        end
    end

    // Issue one event; returns at the edge that accepts it with start still high.
    task automatic send_event(input logic [MODE_W-1:0] m, input logic [LEN_W-1:0] l,
                              input bit typed, input tx_result_t want);
        tx_result_t r;
        start         <= 1'b1;
        mode          <= m;
        packet_length <= l;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        r = advance_sender(m, l);
        if (typed)
            r = want;
        expected_q.push_back(r);
        status_seen[r.status]++;
        events_issued++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (expected_q.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    // Setup, access, then idle with psel low so the next access starts on a fresh edge.
    task automatic apb_access(input logic wr, input logic [CFG_DATA_W-1:0] data,
                              output logic [CFG_DATA_W-1:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_WINDOW_LIMIT;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Write the limit with random upper bits, then read it back.
    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        logic [CFG_DATA_W-1:0] data;
        logic [CFG_DATA_W-1:0] rd;
        data = $urandom();
        data[LIMIT_W-1:0] = v;
        apb_access(1'b1, data, rd);
        win_limit = v;
        apb_access(1'b0, '0, rd);
        compare_field("window_limit", 32'(v), 32'(rd[LIMIT_W-1:0]));
    endtask

    task automatic add_event(input logic [MODE_W-1:0] m, input logic [LEN_W-1:0] l,
                             input int reps, input bit typed, input tx_result_t want);
        plan_row_t row;
        row.kind  = ROW_EVENT;
        row.mode  = m;
        row.len   = l;
        row.reps  = reps;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endtask

    task automatic add_config(input logic [LIMIT_W-1:0] v);
        plan_row_t row;
        row = '{kind: ROW_CONFIG, mode: '0, len: LEN_W'(v), reps: 0, typed: 1'b0, want: '0};
        plan.push_back(row);
    endtask

    function automatic logic [MODE_W-1:0] pick_mode(input event_mix_e mix);
        int r;
        int p_new;
        int p_ack;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  begin p_new = 70; p_ack = 90; end
            MIX_DRAIN: begin p_new = 30; p_ack = 85; end
            default:   begin p_new = 48; p_ack = 83; end
        endcase
        if (r < p_new)
            return MODE_NEW;
        if (r < p_ack)
            return MODE_ACK;
        if (r < 95)
            return MODE_NACK;
        return MODE_SPARE;
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return LEN_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    initial
    begin
        logic [CFG_DATA_W-1:0] rd;
        logic [LIMIT_W-1:0] phase_limit;
        event_mix_e mix;
        bit gappy;
        int burst_left;

        errors = 0;
        events_issued = 0;
        results_seen = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        win_limit = WINDOW_LIMIT_RESET;
        seq_last  = '0;
        id_last   = '0;

        rst_n         <= 1'b0;
        start         <= 1'b0;
        mode          <= MODE_NEW;
        packet_length <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apb_access(1'b0, '0, rd);
        compare_field("window_limit", 32'(WINDOW_LIMIT_RESET), 32'(rd[LIMIT_W-1:0]));

        // Directed: empty window, first sends, resend rotation, limit 0 acting as 1,
        // ACK that cannot release the backlog, raised limit, backlog full.
        add_event(MODE_ACK,   16'h0000, 1, 1, res(1'b0, 0, 0, 0, ST_EMPTY));
        add_event(MODE_NACK,  16'hFFFF, 1, 1, res(1'b0, 0, 0, 0, ST_EMPTY));
        add_event(MODE_SPARE, 16'h0000, 1, 1, res(1'b0, 0, 0, 0, ST_EMPTY));
        add_event(MODE_NEW,   16'h0000, 1, 1, res(1'b1, 1, 1, 16'h0000, ST_SENT));
        add_event(MODE_NEW,   16'hFFFF, 1, 1, res(1'b1, 2, 2, 16'hFFFF, ST_SENT));
        add_event(MODE_NACK,  16'h0000, 1, 1, res(1'b1, 1, 1, 16'h0000, ST_SENT));
        add_event(MODE_SPARE, 16'h0000, 1, 1, res(1'b1, 2, 2, 16'hFFFF, ST_SENT));
        add_config(4'd0);
        add_event(MODE_NEW,   16'h1234, 1, 1, res(1'b0, 0, 0, 0, ST_QUEUED));
        add_event(MODE_ACK,   16'h0000, 1, 1, res(1'b0, 0, 0, 0, ST_ACKED));
        add_event(MODE_ACK,   16'h0000, 1, 1, res(1'b1, 3, 3, 16'h1234, ST_SENT));
        add_event(MODE_NEW,   16'hAAAA, 1, 1, res(1'b0, 0, 0, 0, ST_QUEUED));
        add_config(4'd15);
        add_event(MODE_NEW,   16'h5555, 1, 1, res(1'b0, 0, 0, 0, ST_QUEUED));
        add_event(MODE_ACK,   16'h0000, 1, 1, res(1'b1, 4, 4, 16'hAAAA, ST_SENT));
        add_event(MODE_NEW,   16'h0F0F, BACKLOG_DEPTH - 1, 0, '0);
        add_event(MODE_NEW,   16'hFFFF, 1, 1, res(1'b0, 0, 0, 0, ST_DROPPED));
        add_event(MODE_ACK,   16'h0000, 1, 1, res(1'b1, 5, 5, 16'h5555, ST_SENT));

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CONFIG)
            begin
                wait_idle();
                write_limit(plan[i].len[LIMIT_W-1:0]);
            end
            else
            begin
                repeat (plan[i].reps)
                    send_event(plan[i].mode, plan[i].len, plan[i].typed, plan[i].want);
            end
        end

        // Random phases: extremes of the limit first, then random limits
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph)
                0:       phase_limit = 4'd1;
                1:       phase_limit = 4'd8;
                2:       phase_limit = 4'd0;
                3:       phase_limit = 4'd15;
                default: phase_limit = LIMIT_W'($urandom_range(0, 15));
            endcase
            wait_idle();
            write_limit(phase_limit);
            mix = event_mix_e'($urandom_range(0, 2));
            gappy = (ph % 4) != 1;
            burst_left = 0;
            for (int n = 0; n < PHASE_EVENTS; n++)
            begin
                // Change the event mix now and then to swing between full and empty
                if ($urandom_range(0, 39) == 0)
                    mix = event_mix_e'($urandom_range(0, 2));
                if (burst_left == 0)
                begin
                    if (gappy)
                    begin
                        start <= 1'b0;
                        repeat ($urandom_range(1, 6)) @(posedge clk);
                    end
                    burst_left = $urandom_range(1, 24);
                end
                burst_left--;
                send_event(pick_mode(mix), pick_length(), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (4) @(posedge clk);

        $display("Issued %0d events over %0d random phases, %0d results scored",
                 events_issued, PHASE_COUNT, results_seen);
        $display("Status mix: sent %0d, queued %0d, acked %0d, dropped %0d, empty %0d",
                 status_seen[ST_SENT], status_seen[ST_QUEUED], status_seen[ST_ACKED],
                 status_seen[ST_DROPPED], status_seen[ST_EMPTY]);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
